// ----- src/int64_divide_remainder_defines.svh -----
// ----------------------------------------------------------------------------
// int64_divide_remainder assertion macros
// Shared concurrent assertion forms for the divider checker.
// ----------------------------------------------------------------------------
`ifndef INT64_DIVIDE_REMAINDER_DEFINES_SVH
`define INT64_DIVIDE_REMAINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I64DR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I64DR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- src/i64dr_pkg.sv -----
// ----------------------------------------------------------------------------
// i64dr_pkg
// Types and constants shared by the divider controller, datapath and top.
// ----------------------------------------------------------------------------
package i64dr_pkg;

  // Width of the dividend, divisor and result fields.
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CMD_W   = 2;

  // Command encodings.
  localparam logic [CMD_W-1:0] CMD_SIGNED_QUO   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNED_REM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNSIGNED_QUO = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNSIGNED_REM = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_ITER = 4'b0100,
    ST_FIX  = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands and take magnitudes
    logic prep;    // build the triple-divisor multiple
    logic step;    // retire one radix-4 quotient digit
    logic finish;  // sign fix-up and load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_zero;  // captured divisor is zero
    logic out_free;  // output register can take a new beat
  } dp_status_t;

endpackage

// ----- src/i64dr_if.sv -----
// ----------------------------------------------------------------------------
// i64dr_if
// Valid/ready channel interfaces for the divider request and response.
// ----------------------------------------------------------------------------

// Request channel: command and operands.
interface i64dr_req_if;
  logic                                valid;
  logic                                ready;
  logic [i64dr_pkg::CMD_W-1:0]         command;
  logic [i64dr_pkg::FIELD_W-1:0]       dividend;
  logic [i64dr_pkg::FIELD_W-1:0]       divisor;

  modport source (output valid, output command, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input command, input dividend, input divisor,
                  output ready);
endinterface

// Response channel: result and divide-by-zero flag.
interface i64dr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [i64dr_pkg::FIELD_W-1:0]       result;
  logic                                divide_by_zero;

  modport source (output valid, output result, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

// ----- src/i64dr_ctrl.sv -----
// ----------------------------------------------------------------------------
// i64dr_ctrl
// Sequencer for the divider: load, prepare, iterate digits, fix up, hand off.
// ----------------------------------------------------------------------------
module i64dr_ctrl #(
  parameter int unsigned STEPS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i64dr_pkg::dp_status_t  status_i,
  output i64dr_pkg::ctrl_cmd_t   cmd_o
);

  localparam int unsigned CntW = (STEPS > 1) ? $clog2(STEPS) : 1;

  i64dr_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Next-state and command decode.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      i64dr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = i64dr_pkg::ST_PREP;
        end
      end
      i64dr_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = CntW'(STEPS - 1);
        // A zero divisor skips the digit loop entirely.
        state_d    = status_i.div_zero ? i64dr_pkg::ST_FIX : i64dr_pkg::ST_ITER;
      end
      i64dr_pkg::ST_ITER: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = i64dr_pkg::ST_FIX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      i64dr_pkg::ST_FIX: begin
        // Wait here only while the previous result is still unclaimed.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = i64dr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i64dr_pkg::ST_IDLE;
      end
    endcase
  end

  // State and digit counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i64dr_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- src/i64dr_dpath.sv -----
// ----------------------------------------------------------------------------
// i64dr_dpath
// Divider datapath: operand magnitudes, radix-4 digit recurrence, sign
// fix-up and the output register.
// ----------------------------------------------------------------------------
module i64dr_dpath #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  i64dr_pkg::ctrl_cmd_t                cmd_i,
  output i64dr_pkg::dp_status_t               status_o,
  input  logic [i64dr_pkg::CMD_W-1:0]         command_i,
  input  logic [i64dr_pkg::FIELD_W-1:0]       dividend_i,
  input  logic [i64dr_pkg::FIELD_W-1:0]       divisor_i,
  output logic [i64dr_pkg::FIELD_W-1:0]       result_o,
  output logic                                divide_by_zero_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i
);

  localparam int unsigned FieldW = i64dr_pkg::FIELD_W;
  localparam int unsigned Steps  = (DATA_WIDTH + 1) / 2;
  localparam int unsigned Wq     = 2 * Steps;   // quotient / remainder width
  localparam int unsigned Wr     = Wq + 2;      // shifted partial remainder

  // Operand and sign capture.
  logic                  signed_q, want_rem_q, neg_a_q, neg_b_q, div_zero_q;
  logic [Wq-1:0]         quo_q;      // dividend bits shift out, digits shift in
  logic [Wq-1:0]         rem_q;      // partial remainder
  logic [Wq-1:0]         d1_q;       // divisor magnitude
  logic [Wr-1:0]         d3_q;       // three times the divisor

  logic [FieldW-1:0]     result_q;
  logic                  dbz_out_q;
  logic                  out_valid_q;

  logic                  is_signed;
  logic [DATA_WIDTH-1:0] a_raw, b_raw, a_mag, b_mag;
  logic                  a_neg, b_neg;

  always_comb begin
    is_signed = (command_i == i64dr_pkg::CMD_SIGNED_QUO) ||
                (command_i == i64dr_pkg::CMD_SIGNED_REM);
    a_raw     = dividend_i[DATA_WIDTH-1:0];
    b_raw     = divisor_i[DATA_WIDTH-1:0];
    a_neg     = is_signed & a_raw[DATA_WIDTH-1];
    b_neg     = is_signed & b_raw[DATA_WIDTH-1];
    // The most negative value negates to itself, which is its magnitude.
    a_mag     = a_neg ? (~a_raw + DATA_WIDTH'(1)) : a_raw;
    b_mag     = b_neg ? (~b_raw + DATA_WIDTH'(1)) : b_raw;
  end

  // Radix-4 digit selection against one, two and three divisors.
  logic [Wr-1:0] r4;
  logic [Wr:0]   diff1, diff2, diff3;
  logic [1:0]    digit;
  logic [Wq-1:0] rem_nxt;

  always_comb begin
    r4    = {rem_q, quo_q[Wq-1 -: 2]};
    diff1 = {1'b0, r4} - {1'b0, Wr'(d1_q)};
    diff2 = {1'b0, r4} - {1'b0, Wr'({d1_q, 1'b0})};
    diff3 = {1'b0, r4} - {1'b0, d3_q};
    priority if (!diff3[Wr]) begin
      digit   = 2'd3;
      rem_nxt = diff3[Wq-1:0];
    end else if (!diff2[Wr]) begin
      digit   = 2'd2;
      rem_nxt = diff2[Wq-1:0];
    end else if (!diff1[Wr]) begin
      digit   = 2'd1;
      rem_nxt = diff1[Wq-1:0];
    end else begin
      digit   = 2'd0;
      rem_nxt = r4[Wq-1:0];
    end
  end

  // Sign fix-up of the selected quotient or remainder.
  logic [Wq-1:0]         sel_val;
  logic                  neg_res;
  logic [DATA_WIDTH-1:0] mag_res, fixed_res;

  always_comb begin
    sel_val   = want_rem_q ? rem_q : quo_q;
    neg_res   = signed_q & (want_rem_q ? neg_a_q : (neg_a_q ^ neg_b_q));
    mag_res   = sel_val[DATA_WIDTH-1:0];
    fixed_res = neg_res ? (~mag_res + DATA_WIDTH'(1)) : mag_res;
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      signed_q   <= is_signed;
      want_rem_q <= (command_i == i64dr_pkg::CMD_SIGNED_REM) ||
                    (command_i == i64dr_pkg::CMD_UNSIGNED_REM);
      neg_a_q    <= a_neg;
      neg_b_q    <= b_neg;
      div_zero_q <= (b_raw == '0);
      quo_q      <= Wq'(a_mag);
      rem_q      <= '0;
      d1_q       <= Wq'(b_mag);
    end
    if (cmd_i.prep) begin
      d3_q <= Wr'(d1_q) + Wr'({d1_q, 1'b0});
    end
    if (cmd_i.step) begin
      quo_q <= {quo_q[Wq-3:0], digit};
      rem_q <= rem_nxt;
    end
    if (cmd_i.finish) begin
      result_q  <= div_zero_q ? '0 : FieldW'(fixed_res);
      dbz_out_q <= div_zero_q;
    end
  end

  // Output beat valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_zero = div_zero_q;
  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign result_o          = result_q;
  assign divide_by_zero_o  = dbz_out_q;
  assign out_valid_o       = out_valid_q;

endmodule

// ----- src/int64_divide_remainder.sv -----
// ----------------------------------------------------------------------------
// int64_divide_remainder
// Signed/unsigned 64-bit divider returning quotient or remainder.
//
//   Channel  Dir  Payload                              Beat when
//   in_i     in   command, dividend, divisor           valid & ready
//   out_o    out  result, divide_by_zero               valid & ready
//
// An item passes through load, prepare, the radix-4 digit loop and fix-up
// before output valid; the loop retires STEPS = ceil(DATA_WIDTH/2) digits,
// two quotient bits per cycle. A zero divisor skips the digit loop.
// One item is in flight at a time; the next is accepted while the previous
// result still waits in the output register. Reset clears the sequencer
// and the output valid; a stalled output holds the sequencer in fix-up.
// ----------------------------------------------------------------------------
module int64_divide_remainder #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i64dr_req_if.sink         in_i,
  i64dr_rsp_if.source       out_o
);

  localparam int unsigned Steps = (DATA_WIDTH + 1) / 2;

  i64dr_pkg::ctrl_cmd_t  cmd;
  i64dr_pkg::dp_status_t status;

  // Sequencer.
  i64dr_ctrl #(
    .STEPS (Steps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  i64dr_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .command_i        (in_i.command),
    .dividend_i       (in_i.dividend),
    .divisor_i        (in_i.divisor),
    .result_o         (out_o.result),
    .divide_by_zero_o (out_o.divide_by_zero),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready)
  );

endmodule

// ----- src/i64dr_checker.sv -----
// ----------------------------------------------------------------------------
// i64dr_checker
// Port-level checks on the divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "int64_divide_remainder_defines.svh"

module i64dr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [i64dr_pkg::FIELD_W-1:0] result_i,
  input logic                          divide_by_zero_i
);

  // A response beat stays offered until it is taken.
  `I64DR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A divide by zero always reports a zero result.
  `I64DR_ASSERT_NOW(a_dbz_zero, clk_i, rst_ni, out_valid_i && divide_by_zero_i, result_i == '0)

  // After a request beat the block is busy and takes no second one.
  `I64DR_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // No result can appear in the cycle right after a request beat.
  `I64DR_ASSERT_NEXT(a_no_early, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i))

endmodule

bind int64_divide_remainder i64dr_checker u_i64dr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_i         (out_o.result),
  .divide_by_zero_i (out_o.divide_by_zero)
);

// ----- dv/tb_int64_divide_remainder.sv -----
// ----------------------------------------------------------------------------
// tb_int64_divide_remainder
// Self-checking bench for the signed/unsigned 64-bit divider. Every request
// beat is turned into its exact quotient or remainder by a local predictor,
// and each response beat is compared against the oldest pending prediction.
// Both channels idle at random, and one phase holds the response side off
// long enough that the divider fills up and stalls its request channel.
// ----------------------------------------------------------------------------
module tb_int64_divide_remainder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W = i64dr_pkg::FIELD_W;

  typedef logic [i64dr_pkg::CMD_W-1:0] cmd_t;
  typedef logic [FIELD_W-1:0]          word_t;

  // One response beat as the predictor sees it.
  typedef struct {
    word_t result;
    logic  divide_by_zero;
  } div_result_t;

  localparam word_t       MOST_NEG     = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam word_t       MOST_POS     = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam word_t       MINUS_ONE    = '1;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic clk_i;
  logic rst_ni;

  i64dr_req_if in_if();
  i64dr_rsp_if out_if();

  int64_divide_remainder #(
    .DATA_WIDTH(FIELD_W)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  div_result_t pending_div_results[$];
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned zero_divisor_count;
  int unsigned cmd_count [4];
  int unsigned cycle_count;

  // Idle controls shared between the test phases and the two channel drivers.
  bit          req_no_idle;
  bit          rsp_no_stall;
  int unsigned holds_requested;
  int unsigned holds_served;

  // Clock: 20 ns period.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Exact division at the full field width.
  function automatic div_result_t compute_division(cmd_t cmd, word_t a, word_t b);
    div_result_t r;
    logic        is_signed;
    logic        want_rem;
    logic        neg_a;
    logic        neg_b;
    word_t       mag_a;
    word_t       mag_b;
    word_t       quo;
    word_t       rem;
    is_signed = (cmd == i64dr_pkg::CMD_SIGNED_QUO) || (cmd == i64dr_pkg::CMD_SIGNED_REM);
    want_rem  = (cmd == i64dr_pkg::CMD_SIGNED_REM) || (cmd == i64dr_pkg::CMD_UNSIGNED_REM);
    r.result         = '0;
    r.divide_by_zero = 1'b0;
    if (b == '0) begin
      r.divide_by_zero = 1'b1;
      return r;
    end
    neg_a = is_signed && a[FIELD_W-1];
    neg_b = is_signed && b[FIELD_W-1];
    // The most negative value negates to itself, which is its magnitude.
    mag_a = neg_a ? word_t'(-a) : a;
    mag_b = neg_b ? word_t'(-b) : b;
    quo   = mag_a / mag_b;
    rem   = mag_a % mag_b;
    if (want_rem) begin
      r.result = neg_a ? word_t'(-rem) : rem;
    end else begin
      r.result = (neg_a != neg_b) ? word_t'(-quo) : quo;
    end
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  // Operand values biased toward the interesting corners of the range.
  function automatic word_t pick_operand();
    word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      1: v = word_t'($urandom_range(0, 255));
      2: v = word_t'(-word_t'($urandom_range(1, 255)));
      3: v = word_t'(1) << $urandom_range(0, FIELD_W-1);
      4: v = v >> $urandom_range(1, FIELD_W-1);
      5: v = {{32{v[31]}}, v[31:0]};
      6: begin
        case ($urandom_range(0, 3))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          default: v = '0;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, word_t want, word_t got);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Offers one request beat from a falling edge and returns on a falling edge.
  task automatic send_division(cmd_t cmd, word_t a, word_t b);
    int unsigned gap;
    in_if.valid    = 1'b1;
    in_if.command  = cmd;
    in_if.dividend = a;
    in_if.divisor  = b;
    do @(posedge clk_i); while (!in_if.ready);
    pending_div_results.push_back(compute_division(cmd, a, b));
    cmd_count[cmd]++;
    if (b == '0) zero_divisor_count++;
    @(negedge clk_i);
    gap = req_no_idle ? 0 : idle_length();
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Corners for every command: wrap case, zero divisor, mixed signs.
  task automatic test_directed();
    for (int c = 0; c < 4; c++) begin
      send_division(cmd_t'(c), MOST_NEG, MINUS_ONE);
      send_division(cmd_t'(c), MOST_POS, '0);
      send_division(cmd_t'(c), word_t'(-7), word_t'(2));
      send_division(cmd_t'(c), word_t'(7), word_t'(-2));
    end
    send_division(i64dr_pkg::CMD_SIGNED_QUO,   '0,        MOST_POS);
    send_division(i64dr_pkg::CMD_SIGNED_QUO,   MOST_NEG,  word_t'(1));
    send_division(i64dr_pkg::CMD_SIGNED_QUO,   MOST_NEG,  MOST_NEG);
    send_division(i64dr_pkg::CMD_SIGNED_REM,   MINUS_ONE, MOST_NEG);
    send_division(i64dr_pkg::CMD_UNSIGNED_QUO, MINUS_ONE, word_t'(1));
    send_division(i64dr_pkg::CMD_UNSIGNED_REM, MINUS_ONE, MINUS_ONE);
    send_division(i64dr_pkg::CMD_UNSIGNED_REM, MINUS_ONE, word_t'(3));
    send_division(i64dr_pkg::CMD_SIGNED_REM,   '0,        '0);
  endtask

  // Random commands and operands with a sprinkling of zero divisors.
  task automatic test_random(int unsigned n);
    word_t b;
    for (int unsigned i = 0; i < n; i++) begin
      b = ($urandom_range(0, 29) == 0) ? word_t'(0) : pick_operand();
      send_division(cmd_t'($urandom_range(0, 3)), pick_operand(), b);
    end
  endtask

  // Full-rate traffic with no idling on either channel.
  task automatic test_back_to_back();
    req_no_idle  = 1'b1;
    rsp_no_stall = 1'b1;
    test_random(20);
    req_no_idle  = 1'b0;
    rsp_no_stall = 1'b0;
  endtask

  // Long response hold-off while requests keep coming, so the input stalls.
  task automatic test_output_stall();
    @(posedge clk_i);
    holds_requested++;
    @(negedge clk_i);
    req_no_idle = 1'b1;
    test_random(8);
    req_no_idle = 1'b0;
  endtask

  // Response-side ready: random stalls plus the requested long hold-offs.
  initial begin : rsp_ready_driver
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_requested) begin
        out_if.ready = 1'b0;
        for (int unsigned i = 1; i < LONG_HOLD; i++) @(negedge clk_i);
        holds_served++;
      end else if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (!rsp_no_stall && $urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = idle_length();
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Compare each response beat with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    div_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      checked_count++;
      if (pending_div_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, out_if.result);
      end else begin
        want = pending_div_results.pop_front();
        if (out_if.result !== want.result) begin
          report_mismatch("result", want.result, out_if.result);
        end
        if (out_if.divide_by_zero !== want.divide_by_zero) begin
          report_mismatch("divide_by_zero", word_t'(want.divide_by_zero),
                          word_t'(out_if.divide_by_zero));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_div_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = i64dr_pkg::CMD_SIGNED_QUO;
    in_if.dividend = '0;
    in_if.divisor  = '0;
    req_no_idle    = 1'b0;
    rsp_no_stall   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_back_to_back();
    test_output_stall();
    test_random(RANDOM_ITEMS);

    in_if.valid = 1'b0;
    while (pending_div_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("divisions sent: %0d signed quotient, %0d signed remainder,",
             cmd_count[i64dr_pkg::CMD_SIGNED_QUO], cmd_count[i64dr_pkg::CMD_SIGNED_REM]);
    $display("  %0d unsigned quotient, %0d unsigned remainder",
             cmd_count[i64dr_pkg::CMD_UNSIGNED_QUO], cmd_count[i64dr_pkg::CMD_UNSIGNED_REM]);
    $display("%0d zero divisors, %0d result beats checked, %0d mismatches",
             zero_divisor_count, checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
